// ===== rtl/lcdsnp_pkg.sv =====
// shared types and constants for the character lcd port snoop controller
// no dependencies

package lcdsnp_pkg;

   localparam int COLUMNS_DEF = 16;
   localparam int ROWS_DEF    = 2;

   localparam int ADDR_W = 16;
   localparam int BYTE_W = 8;
   localparam int COL_W  = 6;
   localparam int IDX_W  = 5;
   localparam int REQ_W  = 24;
   localparam int RSP_W  = 40;

   localparam logic [ADDR_W-1:0] PORT_BASE_RST = 16'h6000;
   localparam logic [ADDR_W-1:0] CTRL_OFFSET   = 16'h0001;

   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_LIMIT = 8'h7F;
   localparam logic [BYTE_W-1:0] FUNC_RST   = 8'h38;
   localparam logic [BYTE_W-1:0] ENTRY_RST  = 8'h06;

   localparam logic [BYTE_W-1:0] CMD_CLEAR      = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_MASK_WIDE  = 8'hF8;
   localparam logic [BYTE_W-1:0] CMD_MASK_NARR  = 8'hFC;
   localparam logic [BYTE_W-1:0] CMD_FUNC_SET   = 8'h38;
   localparam logic [BYTE_W-1:0] CMD_DISP_CTRL  = 8'h08;
   localparam logic [BYTE_W-1:0] CMD_ENTRY_MODE = 8'h04;

   localparam int CTRL_RS_BIT = 5;
   localparam int CTRL_RW_BIT = 6;
   localparam int CTRL_E_BIT  = 7;

   typedef enum logic {
      OP_BUS_WRITE = 1'b0,
      OP_CELL_READ = 1'b1
   } op_type;

   typedef struct packed {
      logic [IDX_W-1:0]  written_index;
      logic              char_written;
      logic [BYTE_W-1:0] entry_word;
      logic [BYTE_W-1:0] function_word;
      logic              caret_blink;
      logic              caret_visible;
      logic              disp_enable;
      logic [COL_W-1:0]  pos_col;
      logic              pos_row;
   } status_type;

endpackage

// ===== rtl/lcdsnp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module lcdsnp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/char_lcd_port_snoop_controller.sv =====
// top level of the character lcd port snoop controller
// depends on lcdsnp_pkg and lcdsnp_ram
// path: an accepted request passes the input register, then the result register with the
//   registered cell ram read, before its response is presented
// throughput: one request per cycle; input waits only while a response is held back
// reset: synchronous; cell valid bits clear at once so every cell reads as a space,
//   no clearing pass

module char_lcd_port_snoop_controller #(
   parameter int COLUMNS = lcdsnp_pkg::COLUMNS_DEF,
   parameter int ROWS    = lcdsnp_pkg::ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // address [15:0], value [23:16]
   input  logic [lcdsnp_pkg::REQ_W-1:0]   req_tdata,
   // operation [0]
   input  logic                           req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // read_data [7:0], pos_row [8], pos_col [14:9], disp_enable [15], caret_visible [16],
   // caret_blink [17], function_word [25:18], entry_word [33:26], char_written [34],
   // written_index [39:35]
   output logic [lcdsnp_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_we,
   input  logic [lcdsnp_pkg::ADDR_W-1:0]  csr_wdata
);

   localparam int NCELLS  = ROWS * COLUMNS;
   localparam int CELL_AW = $clog2(NCELLS);
   localparam int ROW_W   = (ROWS > 2) ? 2 : 1;
   localparam int PW      = CELL_AW + 7;
   localparam int COL_W   = lcdsnp_pkg::COL_W;
   localparam int BYTE_W  = lcdsnp_pkg::BYTE_W;
   localparam int ADDR_W  = lcdsnp_pkg::ADDR_W;

   // configuration and display state
   logic [ADDR_W-1:0] port_base_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              disp_ff, disp_in;
   logic              cur_ff, cur_in;
   logic              blink_ff, blink_in;
   logic [BYTE_W-1:0] func_ff, func_in;
   logic [BYTE_W-1:0] entry_ff, entry_in;
   logic [BYTE_W-1:0] latched_ff, latched_in;
   logic              prev_e_ff, prev_e_in;
   logic [NCELLS-1:0] valid_ff, valid_in;

   // input register
   logic                 p_valid_ff;
   lcdsnp_pkg::op_type   p_op_ff;
   logic [ADDR_W-1:0]    p_addr_ff;
   logic [BYTE_W-1:0]    p_value_ff;

   // result register
   logic                   s_valid_ff;
   lcdsnp_pkg::status_type s_status_ff, s_status_in;
   logic                   s_read_ok_ff, s_read_ok_in;
   logic                   s_hit_ff, s_hit_in;

   logic              stall, advance;
   logic              is_data, is_ctrl, fire, printable, on_grid, do_char, do_cmd, do_clear;
   logic [PW-1:0]     pos_wide, rd_wide;
   logic [CELL_AW-1:0] waddr, raddr;
   logic              in_range, is_read;
   logic [BYTE_W-1:0] ram_q, read_data;
   logic [BYTE_W-1:0] cmd;

   assign stall      = s_valid_ff & ~rsp_tready;
   assign advance    = p_valid_ff & ~stall;
   assign req_tready = ~p_valid_ff | ~stall;

   assign is_read = (p_op_ff == lcdsnp_pkg::OP_CELL_READ);
   assign is_data = !is_read && (p_addr_ff == port_base_ff);
   assign is_ctrl = !is_read && (p_addr_ff == port_base_ff + lcdsnp_pkg::CTRL_OFFSET);
   assign fire    = is_ctrl && prev_e_ff && !p_value_ff[lcdsnp_pkg::CTRL_E_BIT]
                    && !p_value_ff[lcdsnp_pkg::CTRL_RW_BIT];
   assign cmd     = latched_ff;

   assign printable = (latched_ff >= lcdsnp_pkg::CHAR_SPACE)
                      && (latched_ff < lcdsnp_pkg::CHAR_LIMIT);
   assign on_grid   = ({1'b0, row_ff} < (ROW_W+1)'(ROWS)) && (col_ff < COL_W'(COLUMNS));
   assign do_char   = fire && p_value_ff[lcdsnp_pkg::CTRL_RS_BIT] && printable && on_grid;
   assign do_cmd    = fire && !p_value_ff[lcdsnp_pkg::CTRL_RS_BIT];
   assign do_clear  = do_cmd && (cmd == lcdsnp_pkg::CMD_CLEAR);

   assign pos_wide = PW'(row_ff) * PW'(COLUMNS) + PW'(col_ff);
   assign waddr    = pos_wide[CELL_AW-1:0];
   assign rd_wide  = PW'(p_addr_ff[lcdsnp_pkg::IDX_W-1:0]);
   assign in_range = rd_wide < PW'(NCELLS);
   assign raddr    = rd_wide[CELL_AW-1:0];

   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      disp_in    = disp_ff;
      cur_in     = cur_ff;
      blink_in   = blink_ff;
      func_in    = func_ff;
      entry_in   = entry_ff;
      latched_in = latched_ff;
      prev_e_in  = prev_e_ff;
      valid_in   = valid_ff;
      if (is_data) begin
         latched_in = p_value_ff;
      end
      if (is_ctrl) begin
         prev_e_in = p_value_ff[lcdsnp_pkg::CTRL_E_BIT];
      end
      if (do_char) begin
         valid_in[waddr] = 1'b1;
         if (col_ff + COL_W'(1) >= COL_W'(COLUMNS)) begin
            col_in = '0;
            row_in = ({1'b0, row_ff} == (ROW_W+1)'(ROWS - 1)) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      if (do_cmd) begin
         if (do_clear) begin
            valid_in = '0;
            row_in   = '0;
            col_in   = '0;
            disp_in  = 1'b1;
            cur_in   = 1'b0;
            blink_in = 1'b0;
            func_in  = lcdsnp_pkg::FUNC_RST;
            entry_in = lcdsnp_pkg::ENTRY_RST;
         end else if ((cmd & lcdsnp_pkg::CMD_MASK_WIDE) == lcdsnp_pkg::CMD_FUNC_SET) begin
            func_in = cmd;
         end else if ((cmd & lcdsnp_pkg::CMD_MASK_WIDE) == lcdsnp_pkg::CMD_DISP_CTRL) begin
            disp_in  = cmd[2];
            cur_in   = cmd[1];
            blink_in = cmd[0];
         end else if ((cmd & lcdsnp_pkg::CMD_MASK_NARR) == lcdsnp_pkg::CMD_ENTRY_MODE) begin
            entry_in = cmd;
         end else if (cmd[7]) begin
            // ddram address, row 1 starts at 0x40
            if (!cmd[6]) begin
               row_in = '0;
               col_in = cmd[COL_W-1:0];
            end else if (cmd[COL_W-1:0] < COL_W'(COLUMNS)) begin
               row_in = ROW_W'(1);
               col_in = cmd[COL_W-1:0];
            end
         end
      end
   end

   always_comb begin
      s_status_in.pos_row       = row_in[0];
      s_status_in.pos_col       = col_in;
      s_status_in.disp_enable   = disp_in;
      s_status_in.caret_visible = cur_in;
      s_status_in.caret_blink   = blink_in;
      s_status_in.function_word = func_in;
      s_status_in.entry_word    = entry_in;
      s_status_in.char_written  = do_char;
      s_status_in.written_index = do_char ? pos_wide[lcdsnp_pkg::IDX_W-1:0] : '0;
      s_read_ok_in              = is_read && in_range;
      s_hit_in                  = is_read && in_range && valid_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_base_ff <= lcdsnp_pkg::PORT_BASE_RST;
      end else if (csr_we) begin
         port_base_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         disp_ff    <= 1'b1;
         cur_ff     <= 1'b0;
         blink_ff   <= 1'b0;
         func_ff    <= lcdsnp_pkg::FUNC_RST;
         entry_ff   <= lcdsnp_pkg::ENTRY_RST;
         latched_ff <= '0;
         prev_e_ff  <= 1'b0;
         valid_ff   <= '0;
      end else if (advance) begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         disp_ff    <= disp_in;
         cur_ff     <= cur_in;
         blink_ff   <= blink_in;
         func_ff    <= func_in;
         entry_ff   <= entry_in;
         latched_ff <= latched_in;
         prev_e_ff  <= prev_e_in;
         valid_ff   <= valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (req_tready) begin
         p_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         p_op_ff    <= lcdsnp_pkg::op_type'(req_tuser);
         p_addr_ff  <= req_tdata[ADDR_W-1:0];
         p_value_ff <= req_tdata[ADDR_W +: BYTE_W];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (!stall) begin
         s_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_status_ff  <= s_status_in;
         s_read_ok_ff <= s_read_ok_in;
         s_hit_ff     <= s_hit_in;
      end
   end

   lcdsnp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (NCELLS)
   ) u_cells (
      .clock (clock),
      .we    (advance && do_char),
      .waddr (waddr),
      .wdata (latched_ff),
      .re    (advance && s_read_ok_in),
      .raddr (raddr),
      .rdata (ram_q)
   );

   // never-written cells read as spaces
   assign read_data = !s_read_ok_ff ? '0 : (s_hit_ff ? ram_q : lcdsnp_pkg::CHAR_SPACE);

   assign rsp_tvalid = s_valid_ff;
   assign rsp_tdata  = {s_status_ff, read_data};

   // assertions
   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> p_valid_ff)
      else $error("accepted request not held in input register");

   a_col_after_write : assert property (@(posedge clock) disable iff (reset)
      s_valid_ff && s_status_ff.char_written |-> s_status_ff.pos_col < COL_W'(COLUMNS))
      else $error("cursor column off grid after a character write");

   a_clear_valid : assert property (@(posedge clock) disable iff (reset)
      $past(advance && do_clear) |-> valid_ff == '0)
      else $error("cell store not cleared by clear command");

endmodule

// ===== tb/sv/tb_char_lcd_port_snoop_controller.sv =====
// testbench for char_lcd_port_snoop_controller: directed and random snooped bus traffic
// on the request stream, responses checked against an in-bench scoreboard with its own lcd model
// depends on lcdsnp_pkg and the rtl of the controller
`timescale 1ns / 1ps

module tb_char_lcd_port_snoop_controller;

   localparam int GRID_COLS  = lcdsnp_pkg::COLUMNS_DEF;
   localparam int GRID_ROWS  = lcdsnp_pkg::ROWS_DEF;
   localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;

   localparam logic [lcdsnp_pkg::BYTE_W-1:0] CTRL_RST   = 8'h0C;
   localparam logic [lcdsnp_pkg::BYTE_W-1:0] DDRAM_FLAG = 8'h80;
   localparam logic [lcdsnp_pkg::BYTE_W-1:0] DDRAM_MASK = 8'h7F;
   localparam logic [lcdsnp_pkg::BYTE_W-1:0] ROW1_START = 8'h40;

   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 330;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS   = 200;

   typedef struct packed {
      lcdsnp_pkg::status_type        st;
      logic [lcdsnp_pkg::BYTE_W-1:0] read_data;
   } lcd_rsp_type;

   class lcd_scoreboard;
      logic [lcdsnp_pkg::BYTE_W-1:0] cells [GRID_CELLS];
      logic                          row;
      logic [lcdsnp_pkg::COL_W-1:0]  col;
      logic                          disp_on, cur_on, blink_on;
      logic [lcdsnp_pkg::BYTE_W-1:0] func_word, entry_word, ctrl_word, latched;
      logic                          prev_e;
      logic [lcdsnp_pkg::ADDR_W-1:0] port_base;
      lcd_rsp_type                   status_queue [$];
      int                            failures;

      function new();
         restore_defaults();
         latched   = '0;
         prev_e    = 1'b0;
         port_base = lcdsnp_pkg::PORT_BASE_RST;
         failures  = 0;
      endfunction

      function void restore_defaults();
         foreach (cells[i]) cells[i] = lcdsnp_pkg::CHAR_SPACE;
         row        = 1'b0;
         col        = '0;
         disp_on    = 1'b1;
         cur_on     = 1'b0;
         blink_on   = 1'b0;
         func_word  = lcdsnp_pkg::FUNC_RST;
         entry_word = lcdsnp_pkg::ENTRY_RST;
         ctrl_word  = CTRL_RST;
      endfunction

      function void run_command(logic [lcdsnp_pkg::BYTE_W-1:0] b);
         logic [6:0] a;
         a = 7'(b & DDRAM_MASK);
         if (b == lcdsnp_pkg::CMD_CLEAR) begin
            restore_defaults();
         end else if ((b & lcdsnp_pkg::CMD_MASK_WIDE) == lcdsnp_pkg::CMD_FUNC_SET) begin
            func_word = b;
         end else if ((b & lcdsnp_pkg::CMD_MASK_WIDE) == lcdsnp_pkg::CMD_DISP_CTRL) begin
            ctrl_word = b;
            disp_on   = b[2];
            cur_on    = b[1];
            blink_on  = b[0];
         end else if ((b & lcdsnp_pkg::CMD_MASK_NARR) == lcdsnp_pkg::CMD_ENTRY_MODE) begin
            entry_word = b;
         end else if ((b & DDRAM_FLAG) != 0) begin
            if (a < ROW1_START) begin
               row = 1'b0;
               col = a[lcdsnp_pkg::COL_W-1:0];
            end else if (int'(a) < int'(ROW1_START) + GRID_COLS) begin
               row = 1'b1;
               col = lcdsnp_pkg::COL_W'(a - ROW1_START);
            end
         end
      endfunction

      function void note_request(lcdsnp_pkg::op_type op,
                                 logic [lcdsnp_pkg::ADDR_W-1:0] addr,
                                 logic [lcdsnp_pkg::BYTE_W-1:0] val);
         lcd_rsp_type                   r;
         logic [lcdsnp_pkg::ADDR_W-1:0] ctrl_addr;
         int                            pos;
         r         = '0;
         ctrl_addr = port_base + lcdsnp_pkg::CTRL_OFFSET;
         if (op == lcdsnp_pkg::OP_CELL_READ) begin
            if (int'(addr[lcdsnp_pkg::IDX_W-1:0]) < GRID_CELLS)
               r.read_data = cells[addr[lcdsnp_pkg::IDX_W-1:0]];
         end else if (addr == port_base) begin
            latched = val;
         end else if (addr == ctrl_addr) begin
            if (prev_e && !val[lcdsnp_pkg::CTRL_E_BIT] && !val[lcdsnp_pkg::CTRL_RW_BIT]) begin
               if (val[lcdsnp_pkg::CTRL_RS_BIT]) begin
                  if (latched >= lcdsnp_pkg::CHAR_SPACE && latched < lcdsnp_pkg::CHAR_LIMIT &&
                      int'(row) < GRID_ROWS && int'(col) < GRID_COLS) begin
                     pos                = int'(row) * GRID_COLS + int'(col);
                     cells[pos]         = latched;
                     r.st.char_written  = 1'b1;
                     r.st.written_index = lcdsnp_pkg::IDX_W'(pos);
                     col                = col + 1'b1;
                     if (int'(col) >= GRID_COLS) begin
                        col = '0;
                        row = 1'((int'(row) + 1) % GRID_ROWS);
                     end
                  end
               end else begin
                  run_command(latched);
               end
            end
            prev_e = val[lcdsnp_pkg::CTRL_E_BIT];
         end
         r.st.pos_row       = row;
         r.st.pos_col       = col;
         r.st.disp_enable   = disp_on;
         r.st.caret_visible = cur_on;
         r.st.caret_blink   = blink_on;
         r.st.function_word = func_word;
         r.st.entry_word    = entry_word;
         status_queue.push_back(r);
      endfunction

      function void compare_field(string name, logic [lcdsnp_pkg::BYTE_W-1:0] e,
                                  logic [lcdsnp_pkg::BYTE_W-1:0] a);
         if (e !== a) begin
            if (failures < MAX_REPORTS)
               $display("%0d ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            failures++;
         end
      endfunction

      function void check_response(logic [lcdsnp_pkg::RSP_W-1:0] data);
         lcd_rsp_type act, exp;
         act = data;
         if (status_queue.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("%0d ns: unexpected response, expected none, actual %0h", $time, data);
            failures++;
            return;
         end
         exp = status_queue.pop_front();
         compare_field("read_data", exp.read_data, act.read_data);
         compare_field("pos_row", 8'(exp.st.pos_row), 8'(act.st.pos_row));
         compare_field("pos_col", 8'(exp.st.pos_col), 8'(act.st.pos_col));
         compare_field("disp_enable", 8'(exp.st.disp_enable), 8'(act.st.disp_enable));
         compare_field("caret_visible", 8'(exp.st.caret_visible), 8'(act.st.caret_visible));
         compare_field("caret_blink", 8'(exp.st.caret_blink), 8'(act.st.caret_blink));
         compare_field("function_word", exp.st.function_word, act.st.function_word);
         compare_field("entry_word", exp.st.entry_word, act.st.entry_word);
         compare_field("char_written", 8'(exp.st.char_written), 8'(act.st.char_written));
         compare_field("written_index", 8'(exp.st.written_index), 8'(act.st.written_index));
      endfunction

      function int pending();
         return status_queue.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [lcdsnp_pkg::REQ_W-1:0]    req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [lcdsnp_pkg::RSP_W-1:0]    rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_we = 1'b0;
   logic [lcdsnp_pkg::ADDR_W-1:0]   csr_wdata = '0;

   lcd_scoreboard                   sb;
   logic [lcdsnp_pkg::ADDR_W-1:0]   port_base_now = lcdsnp_pkg::PORT_BASE_RST;
   bit                              calm = 1'b0;
   int                              items_sent = 0;
   int                              idle_cycles = 0;

   char_lcd_port_snoop_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // response side back-pressure
   initial begin
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_request(lcdsnp_pkg::op_type'(req_tuser),
                            req_tdata[lcdsnp_pkg::ADDR_W-1:0],
                            req_tdata[lcdsnp_pkg::ADDR_W +: lcdsnp_pkg::BYTE_W]);
      end
      if (reset || (rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(input lcdsnp_pkg::op_type op,
                               input logic [lcdsnp_pkg::ADDR_W-1:0] addr,
                               input logic [lcdsnp_pkg::BYTE_W-1:0] val, input bit counted);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {val, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (counted) items_sent++;
   endtask

   task automatic write_ctrl(input logic e, input logic rw, input logic rs);
      send_request(lcdsnp_pkg::OP_BUS_WRITE, port_base_now + lcdsnp_pkg::CTRL_OFFSET,
                   {e, rw, rs, 5'($urandom)}, 1'b1);
   endtask

   task automatic strobe_byte(input logic rs, input logic [lcdsnp_pkg::BYTE_W-1:0] b);
      send_request(lcdsnp_pkg::OP_BUS_WRITE, port_base_now, b, 1'b1);
      write_ctrl(1'b1, 1'b0, rs);
      write_ctrl(1'b0, 1'b0, rs);
   endtask

   task automatic read_cell(input logic [lcdsnp_pkg::IDX_W-1:0] idx);
      send_request(lcdsnp_pkg::OP_CELL_READ, {11'($urandom), idx}, 8'($urandom), 1'b1);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic set_port_base(input logic [lcdsnp_pkg::ADDR_W-1:0] v);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we        <= 1'b0;
      port_base_now = v;
      sb.port_base  = v;
   endtask

   function automatic logic [lcdsnp_pkg::BYTE_W-1:0] pick_command();
      logic [lcdsnp_pkg::BYTE_W-1:0] b;
      b = 8'($urandom);
      case ($urandom_range(0, 15))
         0:       b = lcdsnp_pkg::CMD_CLEAR;
         1, 2:    b = lcdsnp_pkg::CMD_FUNC_SET | (b & 8'h07);
         3, 4:    b = lcdsnp_pkg::CMD_DISP_CTRL | (b & 8'h07);
         5, 6:    b = lcdsnp_pkg::CMD_ENTRY_MODE | (b & 8'h03);
         7, 8, 9: b = DDRAM_FLAG | (b & 8'h0F);
         10, 11:  b = DDRAM_FLAG | ROW1_START | (b & 8'h0F);
         12:      b = DDRAM_FLAG | b;
         default: ;
      endcase
      return b;
   endfunction

   task automatic random_transaction();
      int                            pick;
      logic                          rs;
      logic [lcdsnp_pkg::BYTE_W-1:0] b;
      pick = $urandom_range(0, 99);
      rs   = 1'($urandom);
      if (pick < 62) begin
         if (rs) begin
            b = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom);
         end else begin
            b = pick_command();
         end
         strobe_byte(rs, b);
      end else if (pick < 77) begin
         read_cell(5'($urandom));
      end else if (pick < 85) begin
         send_request(lcdsnp_pkg::OP_BUS_WRITE, 16'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 95) begin
         // broken strobe sequences
         case ($urandom_range(0, 3))
            0: begin
               send_request(lcdsnp_pkg::OP_BUS_WRITE, port_base_now, 8'($urandom), 1'b1);
               write_ctrl(1'b1, 1'b0, rs);
               write_ctrl(1'b0, 1'b1, rs);
            end
            1: write_ctrl(1'b0, 1'b0, rs);
            2: send_request(lcdsnp_pkg::OP_BUS_WRITE, port_base_now, 8'($urandom), 1'b1);
            default: send_request(lcdsnp_pkg::OP_BUS_WRITE,
                                  port_base_now + lcdsnp_pkg::CTRL_OFFSET,
                                  8'($urandom), 1'b1);
         endcase
      end else begin
         send_request(lcdsnp_pkg::OP_BUS_WRITE,
                      $urandom_range(0, 1) ? port_base_now - 16'd1 : port_base_now + 16'd2,
                      8'($urandom), 1'b0);
      end
   endtask

   task automatic run_phase(input int n);
      int target;
      target = items_sent + n;
      while (items_sent < target) random_transaction();
   endtask

   task automatic run_directed();
      read_cell(5'd0);
      send_request(lcdsnp_pkg::OP_CELL_READ, 16'hFFFF, 8'hFF, 1'b1);
      strobe_byte(1'b1, 8'h7E);
      strobe_byte(1'b1, lcdsnp_pkg::CHAR_LIMIT);
      // last cell, then a character that wraps the cursor home
      strobe_byte(1'b0, DDRAM_FLAG | ROW1_START | 8'h0F);
      strobe_byte(1'b1, lcdsnp_pkg::CHAR_SPACE);
      // cursor parked off the grid
      strobe_byte(1'b0, 8'hBF);
      strobe_byte(1'b1, 8'h41);
      strobe_byte(1'b0, 8'hD0);
      strobe_byte(1'b0, 8'h0F);
      write_ctrl(1'b1, 1'b0, 1'b0);
      write_ctrl(1'b0, 1'b1, 1'b0);
      strobe_byte(1'b0, lcdsnp_pkg::CMD_CLEAR);
   endtask

   initial begin
      logic [lcdsnp_pkg::ADDR_W-1:0] bases [4];
      sb       = new();
      bases[0] = 16'h0000;
      bases[1] = 16'hFFF0;
      bases[2] = 16'($urandom_range(0, 16'hFFF0));
      bases[3] = lcdsnp_pkg::PORT_BASE_RST;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase(PHASE_ITEMS);
      foreach (bases[i]) begin
         wait_for_responses();
         set_port_base(bases[i]);
         if (i == 3) calm = 1'b1;
         run_phase(PHASE_ITEMS);
      end
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lcdsnp_pkg.sv
rtl/lcdsnp_ram.sv
rtl/char_lcd_port_snoop_controller.sv
tb/sv/tb_char_lcd_port_snoop_controller.sv
